### rtl/core/bpti_pkg.sv
package bpti_pkg;

    // Table organization
    localparam int NUM_BETAS    = 8;
    localparam int TABLE_POINTS = 1024;
    localparam int TABLE_DEPTH  = 65536;
    localparam int ADDR_W       = 16;
    localparam int BANKS        = 4;
    localparam int BANK_W       = 2;
    localparam int ROW_W        = ADDR_W - BANK_W;
    localparam int BANK_DEPTH   = TABLE_DEPTH / BANKS;
    localparam int STENCIL_LAST = 3;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int G_W      = 24;
    localparam int SEL_W    = 3;
    localparam int L_W      = 2;
    localparam int FX_W     = 24;
    localparam int CFG_W    = 32;
    localparam int VP_W     = 11;
    localparam int TP_W     = $clog2(TABLE_POINTS + 1);
    localparam int LIM_W    = (VP_W > TP_W) ? VP_W : TP_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SPACING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_POINTS    = 2'd2;

    localparam logic [CFG_W-1:0] LATTICE_SCALE_RESET   = 32'd65536;
    localparam logic [CFG_W-1:0] INVERSE_SPACING_RESET = 32'd65536;
    localparam logic [VP_W-1:0]  VALID_POINTS_RESET    = 11'd1024;

    // Norm and square root
    localparam int SQR_W     = 2 * G_W - 1;
    localparam int SUM_W     = 2 * G_W;
    localparam int SQ_EXT_W  = SUM_W + 2;
    localparam int ROOT_W    = 24;
    localparam int SQ_STEPS  = 3;
    localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
    localparam int NORM_LAT  = SQ_STAGES + 2;

    // Position
    localparam int GQ_PROD_W = ROOT_W + CFG_W;
    localparam int GQ_SHIFT  = 12;
    localparam int GQ_W      = GQ_PROD_W - GQ_SHIFT;
    localparam int HALF_W    = 16;
    localparam int PART_W    = GQ_W + HALF_W;
    localparam int POS_W     = PART_W + 1;
    localparam int FRAC_W    = 16;
    localparam int IQ_W      = POS_W - FRAC_W;
    localparam int POS_LAT   = 3;

    // Lagrange weights
    localparam int X1_W     = FRAC_W + 1;
    localparam int X23_W    = FRAC_W + 2;
    localparam int P_W      = 36;
    localparam int Q_W      = P_W + X23_W;
    localparam int W_SHIFT  = 24;
    localparam int V_W      = 27;
    localparam int W_W      = V_W - 1;
    localparam int M_W      = W_W + 32;
    localparam int RECIP_SHIFT = 33;
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
    localparam logic [X23_W-1:0] ONE_Q16   = 18'd65536;
    localparam logic [X23_W-1:0] TWO_Q16   = 18'd131072;
    localparam logic [X23_W-1:0] THREE_Q16 = 18'd196608;
    localparam int TW_W     = WORD_W + W_W + 1;
    localparam int SUMV_W   = TW_W + 2;
    localparam int VQ_W     = SUMV_W - W_SHIFT;
    localparam int INTERP_LAT = 5;

    // Final products
    localparam int FX_SHIFT = 20;
    localparam int A_W      = FX_W + VQ_W - FX_SHIFT;
    localparam int R_W      = A_W + FX_W - FX_SHIFT;
    localparam int ROT_W    = R_W + 1;

    typedef struct packed {
        logic                     valid;
        logic                     cmp;
        logic [ADDR_W-1:0]        table_addr;
        logic signed [WORD_W-1:0] table_word;
        logic [SEL_W-1:0]         atom_type;
        logic [SEL_W-1:0]         beta_index;
        logic [L_W-1:0]           ang_l;
        logic signed [FX_W-1:0]   ylm_value;
        logic signed [FX_W-1:0]   sf_re;
        logic signed [FX_W-1:0]   sf_im;
    } item_t;

endpackage

### rtl/core/bpti_ifs.sv
interface bpti_req_if;
    import bpti_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [ADDR_W-1:0]        table_addr;
    logic signed [WORD_W-1:0] table_word;
    logic signed [G_W-1:0]    g_x;
    logic signed [G_W-1:0]    g_y;
    logic signed [G_W-1:0]    g_z;
    logic [SEL_W-1:0]         atom_type;
    logic [SEL_W-1:0]         beta_index;
    logic [L_W-1:0]           ang_l;
    logic signed [FX_W-1:0]   ylm_value;
    logic signed [FX_W-1:0]   sf_re;
    logic signed [FX_W-1:0]   sf_im;

    modport source (output valid, req_type, table_addr, table_word, g_x, g_y, g_z,
                    atom_type, beta_index, ang_l, ylm_value, sf_re, sf_im,
                    input ready);
    modport sink (input valid, req_type, table_addr, table_word, g_x, g_y, g_z,
                  atom_type, beta_index, ang_l, ylm_value, sf_re, sf_im,
                  output ready);
endinterface

interface bpti_rsp_if;
    import bpti_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] proj_re;
    logic signed [WORD_W-1:0] proj_im;
    logic                     out_of_range;

    modport source (output valid, proj_re, proj_im, out_of_range, input ready);
    modport sink (input valid, proj_re, proj_im, out_of_range, output ready);
endinterface

interface bpti_cfg_if;
    import bpti_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/bpti_ram.sv
module bpti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/bpti_norm.sv
module bpti_norm (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  bpti_pkg::item_t                 item_in,
    input  logic signed [bpti_pkg::G_W-1:0] g_x,
    input  logic signed [bpti_pkg::G_W-1:0] g_y,
    input  logic signed [bpti_pkg::G_W-1:0] g_z,
    output bpti_pkg::item_t                 item_out,
    output logic [bpti_pkg::ROOT_W-1:0]     norm
);
    import bpti_pkg::*;

    item_t             it_reg [NORM_LAT];
    logic [SQR_W-1:0]  sq_reg [3];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  rem_reg [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg [SQ_STAGES];
    logic signed [2*G_W-1:0] sq_x, sq_y, sq_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NORM_LAT; i++)
            begin
                it_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            it_reg[0] <= item_in;
            for (int i = 1; i < NORM_LAT; i++)
            begin
                it_reg[i] <= it_reg[i-1];
            end
        end
    end

    assign sq_x = g_x * g_x;
    assign sq_y = g_y * g_y;
    assign sq_z = g_z * g_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= sq_x[SQR_W-1:0];
            sq_reg[1] <= sq_y[SQR_W-1:0];
            sq_reg[2] <= sq_z[SQR_W-1:0];
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        end
    end

    // Digit-by-digit square root: each stage settles three root bits, keeping
    // the remainder of the radicand minus the square of the partial root.
    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_sqrt
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  rem_c;
        logic [ROOT_W-1:0] root_c;

        if (g == 0)
        begin : g_first
            assign rem_in  = sum_reg;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        always_comb
        begin
            logic [SQ_EXT_W-1:0] r;
            logic [SQ_EXT_W-1:0] q;
            logic [SQ_EXT_W-1:0] trial;
            r = SQ_EXT_W'(rem_in);
            q = SQ_EXT_W'(root_in);
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                trial = (q << (ROOT_W - g * SQ_STEPS - j))
                      + (SQ_EXT_W'(1) << (2 * (ROOT_W - 1 - g * SQ_STEPS - j)));
                if (r >= trial)
                begin
                    r = r - trial;
                    q = q | (SQ_EXT_W'(1) << (ROOT_W - 1 - g * SQ_STEPS - j));
                end
            end
            rem_c  = r[SUM_W-1:0];
            root_c = q[ROOT_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_c;
                root_reg[g] <= root_c;
            end
        end
    end

    assign item_out = it_reg[NORM_LAT-1];
    assign norm     = root_reg[SQ_STAGES-1];
endmodule

### rtl/core/bpti_pos.sv
module bpti_pos (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  bpti_pkg::item_t               item_in,
    input  logic [bpti_pkg::ROOT_W-1:0]   norm,
    input  logic [bpti_pkg::CFG_W-1:0]    lattice_scale,
    input  logic [bpti_pkg::CFG_W-1:0]    inverse_spacing,
    output bpti_pkg::item_t               item_out,
    output logic [bpti_pkg::POS_W-1:0]    pos
);
    import bpti_pkg::*;

    item_t              it_reg [POS_LAT];
    logic [GQ_PROD_W-1:0] prod_reg;
    logic [GQ_W-1:0]    gq;
    logic [PART_W-1:0]  hi_reg;
    logic [PART_W-1:0]  lo_reg;
    logic [POS_W-1:0]   pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POS_LAT; i++)
            begin
                it_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            it_reg[0] <= item_in;
            for (int i = 1; i < POS_LAT; i++)
            begin
                it_reg[i] <= it_reg[i-1];
            end
        end
    end

    assign gq = prod_reg[GQ_PROD_W-1:GQ_SHIFT];

    // The spacing gain is split in integer and fraction halves so that each
    // product stays a narrow multiply.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= GQ_PROD_W'(norm) * GQ_PROD_W'(lattice_scale);
            hi_reg   <= PART_W'(gq) * PART_W'(inverse_spacing[CFG_W-1:HALF_W]);
            lo_reg   <= PART_W'(gq) * PART_W'(inverse_spacing[HALF_W-1:0]);
            pos_reg  <= POS_W'(hi_reg) + POS_W'(lo_reg >> HALF_W);
        end
    end

    assign item_out = it_reg[POS_LAT-1];
    assign pos      = pos_reg;
endmodule

### rtl/core/bpti_interp.sv
module bpti_interp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  bpti_pkg::item_t                    item_in,
    input  logic [bpti_pkg::POS_W-1:0]         pos,
    input  logic [bpti_pkg::VP_W-1:0]          valid_points,
    output bpti_pkg::item_t                    item_out,
    output logic signed [bpti_pkg::VQ_W-1:0]   vq,
    output logic                               oor
);
    import bpti_pkg::*;

    item_t              it_reg [INTERP_LAT];
    logic [IQ_W-1:0]    iq;
    logic [FRAC_W-1:0]  x0;
    logic [X1_W-1:0]    x1;
    logic [X23_W-1:0]   x2, x3;
    logic [LIM_W-1:0]   limit;
    logic               oor_c;
    logic [ADDR_W-1:0]  base;
    logic [ROW_W-1:0]   row_c [BANKS];
    logic [WORD_W-1:0]  rdata [BANKS];
    logic               rd_en;
    logic               wr_en;

    // Stage 1: first weight products, table read issued
    logic [P_W-1:0]     p12_reg, p02_reg, p01_reg;
    logic [X23_W-1:0]   x2_reg, x3_reg;
    logic [BANK_W-1:0]  sel_reg;
    logic [4:0]         oor_reg;
    // Stage 2: full weight products, stencil taps in order
    logic [Q_W-1:0]     q_reg [4];
    logic signed [WORD_W-1:0] t2_reg [4];
    // Stage 3: weight divides
    logic [M_W-1:0]     m0_reg, m3_reg;
    logic [W_W-1:0]     w1_reg, w2_reg;
    logic signed [WORD_W-1:0] t3_reg [4];
    // Stage 4 and 5
    logic signed [TW_W-1:0] tw_reg [4];
    logic signed [VQ_W-1:0] vq_reg;

    logic [V_W-1:0]     v [4];
    logic [W_W-1:0]     w0, w3;
    logic signed [SUMV_W-1:0] acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < INTERP_LAT; i++)
            begin
                it_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            it_reg[0] <= item_in;
            for (int i = 1; i < INTERP_LAT; i++)
            begin
                it_reg[i] <= it_reg[i-1];
            end
        end
    end

    assign iq = pos[POS_W-1:FRAC_W];
    assign x0 = pos[FRAC_W-1:0];
    assign x1 = X1_W'(ONE_Q16 - X23_W'(x0));
    assign x2 = TWO_Q16 - X23_W'(x0);
    assign x3 = THREE_Q16 - X23_W'(x0);

    assign limit = (LIM_W'(valid_points) < LIM_W'(TABLE_POINTS))
                 ? LIM_W'(valid_points) : LIM_W'(TABLE_POINTS);
    assign oor_c = ((IQ_W+1)'(iq) + (IQ_W+1)'(STENCIL_LAST)) >= (IQ_W+1)'(limit);

    assign base = ADDR_W'(32'(item_in.atom_type) * NUM_BETAS * TABLE_POINTS
                + 32'(item_in.beta_index) * TABLE_POINTS
                + 32'(iq[ADDR_W-1:0]));

    // The four stencil points land in four different banks, one read each.
    assign rd_en = en && item_in.valid && item_in.cmp;
    assign wr_en = en && item_in.valid && !item_in.cmp;

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [BANK_W-1:0] k;
        logic [ADDR_W-1:0] addr;

        assign k        = BANK_W'(b) - base[BANK_W-1:0];
        assign addr     = base + ADDR_W'(k);
        assign row_c[b] = addr[ADDR_W-1:BANK_W];

        bpti_ram #(
            .WIDTH (WORD_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en && (item_in.table_addr[BANK_W-1:0] == BANK_W'(b))),
            .waddr (item_in.table_addr[ADDR_W-1:BANK_W]),
            .wdata (item_in.table_word),
            .re    (rd_en),
            .raddr (row_c[b]),
            .rdata (rdata[b])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            v[i] = V_W'(q_reg[i] >> W_SHIFT);
        end
        w0 = W_W'(m0_reg >> RECIP_SHIFT);
        w3 = W_W'(m3_reg >> RECIP_SHIFT);
        acc = SUMV_W'(tw_reg[0]) + SUMV_W'(tw_reg[1])
            - SUMV_W'(tw_reg[2]) + SUMV_W'(tw_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p12_reg <= P_W'(x1) * P_W'(x2);
            p02_reg <= P_W'(x0) * P_W'(x2);
            p01_reg <= P_W'(x0) * P_W'(x1);
            x2_reg  <= x2;
            x3_reg  <= x3;
            sel_reg <= base[BANK_W-1:0];
            oor_reg <= {oor_reg[3:0], oor_c};

            q_reg[0] <= Q_W'(p12_reg) * Q_W'(x3_reg);
            q_reg[1] <= Q_W'(p02_reg) * Q_W'(x3_reg);
            q_reg[2] <= Q_W'(p01_reg) * Q_W'(x3_reg);
            q_reg[3] <= Q_W'(p01_reg) * Q_W'(x2_reg);
            for (int i = 0; i < 4; i++)
            begin
                t2_reg[i] <= $signed(rdata[BANK_W'(sel_reg + BANK_W'(i))]);
                t3_reg[i] <= t2_reg[i];
            end

            // Weights 0 and 3 divide by six: halve, then multiply by the reciprocal of three; 1 and 2 only halve.
            m0_reg <= M_W'(v[0] >> 1) * M_W'(RECIP3);
            m3_reg <= M_W'(v[3] >> 1) * M_W'(RECIP3);
            w1_reg <= W_W'(v[1] >> 1);
            w2_reg <= W_W'(v[2] >> 1);

            tw_reg[0] <= t3_reg[0] * $signed({1'b0, w0});
            tw_reg[1] <= t3_reg[1] * $signed({1'b0, w1_reg});
            tw_reg[2] <= t3_reg[2] * $signed({1'b0, w2_reg});
            tw_reg[3] <= t3_reg[3] * $signed({1'b0, w3});

            vq_reg <= VQ_W'(acc >>> W_SHIFT);
        end
    end

    assign item_out = it_reg[INTERP_LAT-1];
    assign vq       = vq_reg;
    assign oor      = oor_reg[4];
endmodule

### rtl/core/bpti_proj.sv
module bpti_proj (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  bpti_pkg::item_t                     item_in,
    input  logic signed [bpti_pkg::VQ_W-1:0]    vq,
    input  logic                                oor,
    output logic                                out_valid,
    output logic signed [bpti_pkg::WORD_W-1:0]  proj_re,
    output logic signed [bpti_pkg::WORD_W-1:0]  proj_im,
    output logic                                out_of_range
);
    import bpti_pkg::*;

    item_t                    it_reg [2];
    logic signed [A_W-1:0]    a_reg;
    logic signed [R_W-1:0]    re_reg, im_reg;
    logic [1:0]               oor_reg;
    logic signed [A_W+FX_W-1:0]  ya;
    logic signed [R_W+FX_W-1:0]  pre, pim;
    logic signed [ROT_W-1:0]  rot_re, rot_im;
    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] proj_re_reg, proj_im_reg;
    logic                     oor_out_reg;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ROT_W-1:0] x);
        logic signed [ROT_W-1:0] hi;
        logic signed [ROT_W-1:0] lo;
        hi = ROT_W'({1'b0, {(WORD_W-1){1'b1}}});
        lo = -hi - ROT_W'(1);
        if (x > hi)
        begin
            return hi[WORD_W-1:0];
        end
        else if (x < lo)
        begin
            return lo[WORD_W-1:0];
        end
        return x[WORD_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg[0]     <= '0;
            it_reg[1]     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            it_reg[0]     <= item_in;
            it_reg[1]     <= it_reg[0];
            out_valid_reg <= it_reg[1].valid && it_reg[1].cmp;
        end
    end

    assign ya  = item_in.ylm_value * vq;
    assign pre = a_reg * it_reg[0].sf_re;
    assign pim = a_reg * it_reg[0].sf_im;

    // Rotation by a power of minus i swaps and negates the two parts.
    always_comb
    begin
        unique case (it_reg[1].ang_l)
            2'd0:
            begin
                rot_re = ROT_W'(re_reg);
                rot_im = ROT_W'(im_reg);
            end
            2'd1:
            begin
                rot_re = ROT_W'(im_reg);
                rot_im = -ROT_W'(re_reg);
            end
            2'd2:
            begin
                rot_re = -ROT_W'(re_reg);
                rot_im = -ROT_W'(im_reg);
            end
            default:
            begin
                rot_re = -ROT_W'(im_reg);
                rot_im = ROT_W'(re_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= A_W'(ya >>> FX_SHIFT);
            re_reg  <= R_W'(pre >>> FX_SHIFT);
            im_reg  <= R_W'(pim >>> FX_SHIFT);
            oor_reg <= {oor_reg[0], oor};
            proj_re_reg <= oor_reg[1] ? '0 : sat_word(rot_re);
            proj_im_reg <= oor_reg[1] ? '0 : sat_word(rot_im);
            oor_out_reg <= oor_reg[1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign proj_re      = proj_re_reg;
    assign proj_im      = proj_im_reg;
    assign out_of_range = oor_out_reg;
endmodule

### rtl/core/beta_projector_table_interpolator.sv
// Throughput: one item per cycle while the pipeline is not held; load items write the
// table and give no result. The whole pipeline advances together and holds when
// the result register is full and not taken; the deepest part is the 8-stage
// square root.
// Reset clears every valid bit and sets the configuration registers to their
// defaults; the radial table holds no defined value until it is loaded.
module beta_projector_table_interpolator (
    input  logic       clk,
    input  logic       rst_n,
    bpti_cfg_if.sink   cfg,
    bpti_req_if.sink   req,
    bpti_rsp_if.source rsp
);
    import bpti_pkg::*;

    logic [CFG_W-1:0] lattice_scale_reg;
    logic [CFG_W-1:0] inverse_spacing_reg;
    logic [VP_W-1:0]  valid_points_reg;

    logic              en;
    item_t             item_in;
    item_t             norm_item, pos_item, interp_item;
    logic [ROOT_W-1:0] norm;
    logic [POS_W-1:0]  pos;
    logic signed [VQ_W-1:0] vq;
    logic              oor;
    logic              out_valid;

    // Configuration writes are always taken. The user must send them only while the
    // pipeline is empty, so no item sees a register change under it; the block does not check.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lattice_scale_reg   <= LATTICE_SCALE_RESET;
            inverse_spacing_reg <= INVERSE_SPACING_RESET;
            valid_points_reg    <= VALID_POINTS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LATTICE_SCALE:   lattice_scale_reg   <= cfg.data;
                REG_INVERSE_SPACING: inverse_spacing_reg <= cfg.data;
                REG_VALID_POINTS:    valid_points_reg    <= cfg.data[VP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Every stage moves when the result register is empty or being taken in
    // this cycle; the same enable admits the next item at the input.
    assign en        = !out_valid || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        item_in.valid      = req.valid;
        item_in.cmp        = req.req_type;
        item_in.table_addr = req.table_addr;
        item_in.table_word = req.table_word;
        item_in.atom_type  = req.atom_type;
        item_in.beta_index = req.beta_index;
        item_in.ang_l      = req.ang_l;
        item_in.ylm_value  = req.ylm_value;
        item_in.sf_re      = req.sf_re;
        item_in.sf_im      = req.sf_im;
    end

    // Squares, their sum and the pipelined integer square root of |G|^2.
    bpti_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .item_in  (item_in),
        .g_x      (req.g_x),
        .g_y      (req.g_y),
        .g_z      (req.g_z),
        .item_out (norm_item),
        .norm     (norm)
    );

    // Scaling of |G| by the lattice factor and the reciprocal grid spacing.
    bpti_pos u_pos (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .item_in         (norm_item),
        .norm            (norm),
        .lattice_scale   (lattice_scale_reg),
        .inverse_spacing (inverse_spacing_reg),
        .item_out        (pos_item),
        .pos             (pos)
    );

    // Range check, Lagrange weights and the four-bank radial table. Load
    // items write the table here, in order with the reads of compute items.
    bpti_interp u_interp (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .item_in      (pos_item),
        .pos          (pos),
        .valid_points (valid_points_reg),
        .item_out     (interp_item),
        .vq           (vq),
        .oor          (oor)
    );

    // Harmonic and structure factor products, rotation and saturation.
    bpti_proj u_proj (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .item_in      (interp_item),
        .vq           (vq),
        .oor          (oor),
        .out_valid    (out_valid),
        .proj_re      (rsp.proj_re),
        .proj_im      (rsp.proj_im),
        .out_of_range (rsp.out_of_range)
    );

    assign rsp.valid = out_valid;
endmodule
